FILE: sv/prfe_pkg.sv
// Shared types and constants for the planar rectangle fill engine.
`default_nettype none
package prfe_pkg;
   localparam logic [1:0] KIND_FILL = 2'd0;
   localparam logic [1:0] KIND_READ = 2'd1;
   localparam logic [1:0] KIND_FLIP = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic        empty;
      logic [3:0]  color;
      logic [10:0] x0;
      logic [10:0] xl;
      logic [9:0]  y0;
      logic [9:0]  yl;
      logic        read_page;
      logic [14:0] read_address;
   } cmd_type;
endpackage
`default_nettype wire

FILE: sv/planar_rect_fill_engine.sv
// Fill: RD, WAIT, WR per byte word touched, then RESP; read: WAIT, RESP.
// Rate is set by the single-port frame store read-modify-write sequencer.
// A 4-entry command queue decouples clipping from the store sequencer.
// Synchronous active-high reset: draw page 1, frame count 0, queue empty.
// Frame store contents are undefined until written; there is no clearing pass.
`default_nettype none
module planar_rect_fill_engine #(
   parameter int SCREEN_WIDTH  = 640,
   parameter int SCREEN_HEIGHT = 400,
   parameter int PAGE_WORDS    = 32768
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_kind,
   input  wire logic signed [15:0] req_rect_x,
   input  wire logic signed [15:0] req_rect_y,
   input  wire logic signed [15:0] req_rect_width,
   input  wire logic signed [15:0] req_rect_height,
   input  wire logic [3:0]         req_fill_color,
   input  wire logic               req_read_page,
   input  wire logic [14:0]        req_read_address,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_status,
   output logic [7:0]              rsp_plane_blue,
   output logic [7:0]              rsp_plane_red,
   output logic [7:0]              rsp_plane_green,
   output logic [7:0]              rsp_plane_intensity,
   output logic                    rsp_shown_page,
   output logic [31:0]             rsp_frames_flipped
);
   logic f_valid, f_ready, q_valid, q_ready;
   prfe_pkg::cmd_type f_cmd, q_cmd;

   prfe_front #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_front (
      .clock, .reset, .in_valid(req_valid), .in_ready(req_ready), .kind(req_kind),
      .rect_x(req_rect_x), .rect_y(req_rect_y), .rect_width(req_rect_width),
      .rect_height(req_rect_height), .fill_color(req_fill_color),
      .read_page(req_read_page), .read_address(req_read_address),
      .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd));

   prfe_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
      .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd));

   prfe_back #(.SCREEN_WIDTH(SCREEN_WIDTH), .PAGE_WORDS(PAGE_WORDS)) u_back (
      .clock, .reset, .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_plane_blue, .rsp_plane_red,
      .rsp_plane_green, .rsp_plane_intensity, .rsp_shown_page, .rsp_frames_flipped);

   a_flip_count: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && rsp_frames_flipped != $past(rsp_frames_flipped) |->
      rsp_shown_page != $past(rsp_shown_page))
      else $error("frame count moved without a page swap");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result word dropped while stalled");
   a_status_planes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_plane_blue == 8'd0 && rsp_plane_red == 8'd0)
      else $error("empty fill carries plane data");
endmodule
`default_nettype wire

FILE: sv/prfe_front.sv
// Front end: clips fill rectangles and classifies incoming words.
`default_nettype none
module prfe_front #(
   parameter int SCREEN_WIDTH  = 640,
   parameter int SCREEN_HEIGHT = 400
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic [1:0]         kind,
   input  wire logic signed [15:0] rect_x,
   input  wire logic signed [15:0] rect_y,
   input  wire logic signed [15:0] rect_width,
   input  wire logic signed [15:0] rect_height,
   input  wire logic [3:0]         fill_color,
   input  wire logic               read_page,
   input  wire logic [14:0]        read_address,
   output logic                    cmd_valid,
   input  wire logic               cmd_ready,
   output prfe_pkg::cmd_type       cmd
);
   logic signed [16:0] x0, y0, x1, y1;
   logic               empty;
   prfe_pkg::cmd_type  c_in;
   prfe_pkg::cmd_type  c_ff;
   logic               v_ff;

   always_comb begin
      x0 = 17'(rect_x);
      y0 = 17'(rect_y);
      x1 = 17'(rect_x) + 17'(rect_width);
      y1 = 17'(rect_y) + 17'(rect_height);
      if (x0 < 0) x0 = '0;
      if (y0 < 0) y0 = '0;
      if (x1 > 17'(SCREEN_WIDTH)) x1 = 17'(SCREEN_WIDTH);
      if (y1 > 17'(SCREEN_HEIGHT)) y1 = 17'(SCREEN_HEIGHT);
      empty = (rect_width <= 0) || (rect_height <= 0) || (x0 >= x1) || (y0 >= y1);
      c_in.kind = kind;
      c_in.empty = empty;
      c_in.color = fill_color;
      c_in.x0 = x0[10:0];
      c_in.xl = 11'(x1 - 17'sd1);
      c_in.y0 = y0[9:0];
      c_in.yl = 10'(y1 - 17'sd1);
      c_in.read_page = read_page;
      c_in.read_address = read_address;
   end

   assign in_ready  = !v_ff || cmd_ready;
   assign cmd_valid = v_ff;
   assign cmd       = c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         c_ff <= c_in;
      end
   end
endmodule
`default_nettype wire

FILE: sv/prfe_queue.sv
// Short command queue between front and back ends.
`default_nettype none
module prfe_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  prfe_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  wire logic        out_ready,
   output prfe_pkg::cmd_type out_cmd
);
   prfe_pkg::cmd_type mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = cnt_ff != 3'd4;
   assign out_valid = cnt_ff != 3'd0;
   assign out_cmd   = mem_ff[rp_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 2'd1;
         if (pop) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(pop);
      end
      if (push) mem_ff[wp_ff] <= in_cmd;
   end
endmodule
`default_nettype wire

FILE: sv/prfe_back.sv
// Back end: row/byte sequencer, masked frame store read-modify-write, reads, flips.
`default_nettype none
module prfe_back #(
   parameter int SCREEN_WIDTH = 640,
   parameter int PAGE_WORDS   = 32768
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        cmd_valid,
   output logic             cmd_ready,
   input  prfe_pkg::cmd_type cmd,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_status,
   output logic [7:0]       rsp_plane_blue,
   output logic [7:0]       rsp_plane_red,
   output logic [7:0]       rsp_plane_green,
   output logic [7:0]       rsp_plane_intensity,
   output logic             rsp_shown_page,
   output logic [31:0]      rsp_frames_flipped
);
   localparam int PW      = $clog2(PAGE_WORDS);
   localparam int AW      = PW + 1;
   localparam int RowBytes = SCREEN_WIDTH / 8;
   localparam int OW      = 20;

   typedef enum logic [2:0] {IDLE, RD, WAIT, WR, RESP} state_type;

   logic [31:0]       mem [2**AW];
   logic [31:0]       rdata_ff;
   state_type         st_ff, st_in;
   prfe_pkg::cmd_type c_ff, c_in;
   logic [7:0]        col_ff, col_in;
   logic [9:0]        row_ff, row_in;
   logic [OW-1:0]     base_ff, base_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic              draw_ff, draw_in;
   logic [31:0]       cnt_ff, cnt_in;
   logic              v_ff, v_in, status_ff, status_in;
   logic [31:0]       word_ff, word_in;
   logic              wen;
   logic [31:0]       wdata;
   logic [7:0]        mask, lb, rb;
   logic [OW-1:0]     off;

   assign lb  = c_ff.x0[10:3];
   assign rb  = c_ff.xl[10:3];
   assign off = base_ff + OW'(col_ff);

   always_comb begin
      mask = 8'hFF;
      if (col_ff == lb) mask = mask & (8'hFF >> c_ff.x0[2:0]);
      if (col_ff == rb) mask = mask & 8'(8'hFF << (3'd7 - c_ff.xl[2:0]));
      for (int p = 0; p < 4; p++) begin
         wdata[8*p +: 8] = (rdata_ff[8*p +: 8] & ~mask) | ({8{c_ff.color[p]}} & mask);
      end
   end

   assign cmd_ready = st_ff == IDLE && !(v_ff && !rsp_ready);

   always_comb begin
      st_in = st_ff; c_in = c_ff; col_in = col_ff; row_in = row_ff; base_in = base_ff;
      addr_in = addr_ff; draw_in = draw_ff; cnt_in = cnt_ff; v_in = v_ff;
      status_in = status_ff; word_in = word_ff; wen = 1'b0;
      if (v_ff && rsp_ready) v_in = 1'b0;
      unique case (st_ff)
         IDLE: begin
            if (cmd_valid && cmd_ready) begin
               c_in = cmd;
               status_in = 1'b0;
               word_in = '0;
               unique case (cmd.kind)
                  prfe_pkg::KIND_FILL: begin
                     if (cmd.empty) begin
                        status_in = 1'b1;
                        v_in = 1'b1;
                     end else begin
                        row_in = cmd.y0;
                        col_in = cmd.x0[10:3];
                        base_in = OW'(cmd.y0) * OW'(RowBytes);
                        st_in = RD;
                     end
                  end
                  prfe_pkg::KIND_READ: begin
                     addr_in = {cmd.read_page, PW'(cmd.read_address)};
                     st_in = WAIT;
                  end
                  prfe_pkg::KIND_FLIP: begin
                     draw_in = !draw_ff;
                     cnt_in = cnt_ff + 32'd1;
                     v_in = 1'b1;
                  end
                  default: v_in = 1'b1;
               endcase
            end
         end
         RD: begin
            addr_in = {draw_ff, PW'(off % OW'(PAGE_WORDS))};
            st_in = WAIT;
         end
         WAIT: begin
            if (c_ff.kind == prfe_pkg::KIND_READ) begin
               st_in = RESP;
            end else begin
               st_in = WR;
            end
         end
         WR: begin
            wen = 1'b1;
            if (col_ff == rb) begin
               col_in = lb;
               if (row_ff == c_ff.yl) begin
                  st_in = RESP;
               end else begin
                  row_in = row_ff + 10'd1;
                  base_in = base_ff + OW'(RowBytes);
                  st_in = RD;
               end
            end else begin
               col_in = col_ff + 8'd1;
               st_in = RD;
            end
         end
         RESP: begin
            if (!v_ff || rsp_ready) begin
               if (c_ff.kind == prfe_pkg::KIND_READ) word_in = rdata_ff;
               v_in = 1'b1;
               st_in = IDLE;
            end
         end
         default: st_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= IDLE;
         v_ff <= 1'b0;
         draw_ff <= 1'b1;
         cnt_ff <= '0;
      end else begin
         st_ff <= st_in;
         v_ff <= v_in;
         draw_ff <= draw_in;
         cnt_ff <= cnt_in;
      end
      c_ff <= c_in; col_ff <= col_in; row_ff <= row_in; base_ff <= base_in;
      addr_ff <= addr_in; status_ff <= status_in; word_ff <= word_in;
   end

   always_ff @(posedge clock) begin
      if (wen) mem[addr_ff] <= wdata;
      rdata_ff <= mem[addr_ff];
   end

   assign rsp_valid = v_ff;
   assign rsp_status = status_ff;
   assign rsp_plane_blue = word_ff[7:0];
   assign rsp_plane_red = word_ff[15:8];
   assign rsp_plane_green = word_ff[23:16];
   assign rsp_plane_intensity = word_ff[31:24];
   assign rsp_shown_page = !draw_ff;
   assign rsp_frames_flipped = cnt_ff;
endmodule
`default_nettype wire
